[rtl/tccc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// tccc_pkg
// Shared types and constants of the text console cell controller: opcodes,
// control characters, configuration register indexes, queue word and
// result word layouts, and the sequencer states.
// ============================================================================
package tccc_pkg;

    // Default sizes of the cell store and the tab stop spacing
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 128;
    localparam int DEF_TAB_WIDTH   = 4;

    // Register values after reset
    localparam int COLS_RESET = 80;
    localparam int ROWS_RESET = 25;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 2'd1;

    // Opcodes
    localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [2:0] OP_READ_CELL  = 3'd1;
    localparam logic [2:0] OP_CLEAR      = 3'd2;
    localparam logic [2:0] OP_WRITE_CELL = 3'd3;
    localparam logic [2:0] OP_SET_CURSOR = 3'd4;

    // Characters
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_QMARK    = 8'h3F;
    localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_BS       = 8'h08;
    localparam logic [7:0] CHAR_DEL      = 8'h7F;
    localparam logic [7:0] CHAR_TAB      = 8'h09;

    // Queue between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [3:0] {
        KIND_PUT,
        KIND_LF,
        KIND_CR,
        KIND_BS,
        KIND_TAB,
        KIND_READ,
        KIND_CLEAR,
        KIND_WRITE,
        KIND_SETCUR,
        KIND_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic [6:0] row_in;
        logic [7:0] col_in;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic       cell_written;
        logic [6:0] cell_row;
        logic [7:0] cell_col;
        logic [7:0] cell_char;
        logic [6:0] cursor_row_out;
        logic [7:0] cursor_col_out;
        logic       scrolled;
        logic [7:0] read_char;
        logic       last_result;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAB_DIV,
        ST_TAB_REM,
        ST_STEP,
        ST_READ,
        ST_ROW_SWEEP
    } ctl_state_t;

endpackage

[rtl/tccc_ifs.sv]
`timescale 1ns / 1ps
// ============================================================================
// tccc channel interfaces
// Command, result and configuration channels, each a valid/ready handshake
// with its payload.
// ============================================================================
interface tccc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] char_in;
    logic [6:0] row_in;
    logic [7:0] col_in;

    modport source (output valid, output opcode, output char_in, output row_in,
                    output col_in, input ready);
    modport sink (input valid, input opcode, input char_in, input row_in,
                  input col_in, output ready);
endinterface

interface tccc_rsp_if;
    logic       valid;
    logic       ready;
    logic       cell_written;
    logic [6:0] cell_row;
    logic [7:0] cell_col;
    logic [7:0] cell_char;
    logic [6:0] cursor_row_out;
    logic [7:0] cursor_col_out;
    logic       scrolled;
    logic [7:0] read_char;
    logic       last_result;

    modport source (output valid, output cell_written, output cell_row,
                    output cell_col, output cell_char, output cursor_row_out,
                    output cursor_col_out, output scrolled, output read_char,
                    output last_result, input ready);
    modport sink (input valid, input cell_written, input cell_row,
                  input cell_col, input cell_char, input cursor_row_out,
                  input cursor_col_out, input scrolled, input read_char,
                  input last_result, output ready);
endinterface

interface tccc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/tccc_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// tccc_front
// Accepts command words and classifies them: control characters are
// separated from printable bytes and cell content is filtered to printable
// ASCII before the word enters the queue.
// ============================================================================
module tccc_front (
    tccc_cmd_if.sink          cmd,
    input  logic              q_full,
    output tccc_pkg::q_push_t push
);
    import tccc_pkg::*;

    // Map bytes outside the printable range to a question mark
    function automatic logic [7:0] filter_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b < CHAR_PRINT_LO || b > CHAR_PRINT_HI)
        begin
            r = CHAR_QMARK;
        end
        return r;
    endfunction

    assign cmd.ready = !q_full;

    // Classify the incoming word
    always_comb
    begin
        push.valid        = cmd.valid && !q_full;
        push.entry.kind   = KIND_NOP;
        push.entry.ch     = filter_byte(cmd.char_in);
        push.entry.row_in = cmd.row_in;
        push.entry.col_in = cmd.col_in;
        case (cmd.opcode)
            OP_PUT_CHAR:
            begin
                case (cmd.char_in)
                    CHAR_LF:  push.entry.kind = KIND_LF;
                    CHAR_CR:  push.entry.kind = KIND_CR;
                    CHAR_BS:  push.entry.kind = KIND_BS;
                    CHAR_DEL: push.entry.kind = KIND_BS;
                    CHAR_TAB: push.entry.kind = KIND_TAB;
                    default:  push.entry.kind = KIND_PUT;
                endcase
            end
            OP_READ_CELL:  push.entry.kind = KIND_READ;
            OP_CLEAR:      push.entry.kind = KIND_CLEAR;
            OP_WRITE_CELL: push.entry.kind = KIND_WRITE;
            OP_SET_CURSOR: push.entry.kind = KIND_SETCUR;
            default:       push.entry.kind = KIND_NOP;
        endcase
    end

endmodule

[rtl/tccc_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// tccc_queue
// Short queue of classified command words between the front and the back,
// so that each side stalls on its own.
// ============================================================================
module tccc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  tccc_pkg::q_push_t push,
    output logic              full,
    input  logic              pop,
    output tccc_pkg::q_head_t head
);
    import tccc_pkg::*;

    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    q_entry_t           slot_reg [Q_DEPTH];
    logic [QPW-1:0]     wr_ptr_reg;
    logic [QPW-1:0]     wr_ptr_next;
    logic [QPW-1:0]     rd_ptr_reg;
    logic [QPW-1:0]     rd_ptr_next;
    logic [QCW-1:0]     count_reg;
    logic [QCW-1:0]     count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == QCW'(Q_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QPW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QPW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

[rtl/tccc_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// tccc_back
// Carries out queued commands against the cell store: cursor movement,
// wrapping, ring-offset scrolling with a row sweep, whole-store clear
// sweep, cell reads and writes, and the registered result word.
// ============================================================================
module tccc_back #(
    parameter int MAX_COLUMNS = tccc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tccc_pkg::DEF_MAX_ROWS,
    parameter int TAB_WIDTH   = tccc_pkg::DEF_TAB_WIDTH,
    localparam int CNW        = $clog2(MAX_COLUMNS + 1),
    localparam int RNW        = $clog2(MAX_ROWS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tccc_pkg::q_head_t head,
    output logic              pop,
    input  logic [CNW-1:0]    shown_cols,
    input  logic [RNW-1:0]    shown_rows,
    tccc_rsp_if.source        rsp
);
    import tccc_pkg::*;

    localparam int CW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW     = RW + CW;
    localparam int DEPTH  = MAX_ROWS * (2 ** CW);
    localparam int TBW    = $clog2(TAB_WIDTH + 1);
    localparam int DS     = CW + 4;
    localparam int RECIP  = (2 ** DS) / TAB_WIDTH;
    localparam int PW     = CW + DS;
    localparam int RMW    = CW + 5;

    // Store row of a screen row under a given ring offset
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                               input logic [RW-1:0] t);
        logic [RW:0] s;
        s = {1'b0, r} + {1'b0, t};
        if (s >= (RW + 1)'(MAX_ROWS))
        begin
            s = s - (RW + 1)'(MAX_ROWS);
        end
        return s[RW-1:0];
    endfunction

    // Cell store
    logic [7:0]     mem [DEPTH];
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_data_reg;

    // Control state
    ctl_state_t     state_reg;
    ctl_state_t     state_next;
    q_entry_t       it_reg;
    q_entry_t       it_next;
    logic [RW-1:0]  cur_row_reg;
    logic [RW-1:0]  cur_row_next;
    logic [CW-1:0]  cur_col_reg;
    logic [CW-1:0]  cur_col_next;
    logic [RW-1:0]  top_reg;
    logic [RW-1:0]  top_next;
    logic [1:0]     tab_cnt_reg;
    logic [1:0]     tab_cnt_next;
    logic [TBW-1:0] tab_rem_reg;
    logic [TBW-1:0] tab_rem_next;
    logic [CW-1:0]  tab_q_reg;
    logic [CW-1:0]  tab_q_next;
    logic [RW-1:0]  swp_row_reg;
    logic [RW-1:0]  swp_row_next;
    logic [CW-1:0]  swp_col_reg;
    logic [CW-1:0]  swp_col_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    rsp_word_t      out_word_reg;
    rsp_word_t      out_word_next;

    // Geometry
    logic [CW-1:0]  cols_m1;
    logic [RW-1:0]  rows_m1;
    logic           out_free;
    logic           col_end;
    logic           row_end;

    // Step results
    logic           nl_scroll;
    logic [RW-1:0]  nl_row;
    logic [RW-1:0]  nl_top;
    logic           col_wrap;
    logic           wr_in_range;
    logic [RMW-1:0] rem_diff;
    logic           s_wr;
    logic [RW-1:0]  s_wr_row;
    logic [CW-1:0]  s_wr_col;
    logic [7:0]     s_wr_ch;
    logic [RW-1:0]  s_cr;
    logic [CW-1:0]  s_cc;
    logic [RW-1:0]  s_top;
    logic           s_scroll;
    logic           s_done;
    logic           s_emit;
    rsp_word_t      s_word;
    logic           step_go;
    logic           read_go;

    assign cols_m1  = CW'(shown_cols - CNW'(1));
    assign rows_m1  = RW'(shown_rows - RNW'(1));
    assign out_free = !out_valid_reg || rsp.ready;
    assign col_end  = (swp_col_reg == CW'(MAX_COLUMNS - 1));
    assign row_end  = (swp_row_reg == RW'(MAX_ROWS - 1));
    assign rd_addr  = {phys_row(RW'(head.entry.row_in), top_reg), CW'(head.entry.col_in)};
    assign step_go  = (state_reg == ST_STEP) && (!s_emit || out_free);
    assign read_go  = (state_reg == ST_READ) && out_free;

    assign wr_in_range = (32'(it_reg.row_in) < 32'(shown_rows))
                      && (32'(it_reg.col_in) < 32'(shown_cols));

    // Newline and wrap helpers on the current cursor
    assign nl_scroll = (RNW'(cur_row_reg) + RNW'(1)) >= shown_rows;
    assign nl_row    = nl_scroll ? rows_m1 : cur_row_reg + RW'(1);
    assign nl_top    = (top_reg == RW'(MAX_ROWS - 1)) ? '0 : top_reg + RW'(1);
    assign col_wrap  = (CNW'(cur_col_reg) + CNW'(1)) >= shown_cols;

    // Tab remainder from the registered quotient estimate
    assign rem_diff = RMW'(cur_col_reg) - RMW'(tab_q_reg) * RMW'(TAB_WIDTH);

    // Work out one step of the current command
    always_comb
    begin
        s_wr     = 1'b0;
        s_wr_row = cur_row_reg;
        s_wr_col = cur_col_reg;
        s_wr_ch  = CHAR_SPACE;
        s_cr     = cur_row_reg;
        s_cc     = cur_col_reg;
        s_top    = top_reg;
        s_scroll = 1'b0;
        s_done   = 1'b1;
        s_emit   = 1'b1;
        s_word   = '0;
        case (it_reg.kind)
            KIND_PUT, KIND_TAB:
            begin
                s_wr    = 1'b1;
                s_wr_ch = (it_reg.kind == KIND_TAB) ? CHAR_SPACE : it_reg.ch;
                if (col_wrap)
                begin
                    s_cc     = '0;
                    s_cr     = nl_row;
                    s_scroll = nl_scroll;
                    s_top    = nl_scroll ? nl_top : top_reg;
                end
                else
                begin
                    s_cc = cur_col_reg + CW'(1);
                end
                if (it_reg.kind == KIND_TAB)
                begin
                    s_done = col_wrap || ((tab_rem_reg + TBW'(1)) == TBW'(TAB_WIDTH));
                    s_emit = s_done || (tab_cnt_reg != 2'd3);
                end
            end
            KIND_LF:
            begin
                s_cc     = '0;
                s_cr     = nl_row;
                s_scroll = nl_scroll;
                s_top    = nl_scroll ? nl_top : top_reg;
            end
            KIND_CR:
            begin
                s_cc = '0;
            end
            KIND_BS:
            begin
                if (cur_col_reg != '0)
                begin
                    s_cc = cur_col_reg - CW'(1);
                end
                else if (cur_row_reg != '0)
                begin
                    s_cr = cur_row_reg - RW'(1);
                    s_cc = cols_m1;
                end
                s_wr     = 1'b1;
                s_wr_row = s_cr;
                s_wr_col = s_cc;
            end
            KIND_WRITE:
            begin
                s_wr     = wr_in_range;
                s_wr_row = RW'(it_reg.row_in);
                s_wr_col = CW'(it_reg.col_in);
                s_wr_ch  = it_reg.ch;
            end
            KIND_SETCUR:
            begin
                s_cr = (32'(it_reg.row_in) >= 32'(shown_rows)) ? rows_m1 : RW'(it_reg.row_in);
                s_cc = (32'(it_reg.col_in) >= 32'(shown_cols)) ? cols_m1 : CW'(it_reg.col_in);
            end
            KIND_CLEAR:
            begin
                s_cr  = '0;
                s_cc  = '0;
                s_top = '0;
            end
            default:
            begin
                s_done = 1'b1;
            end
        endcase
        s_word.cell_written   = s_wr;
        s_word.cell_row       = s_wr ? 7'(s_wr_row) : 7'd0;
        s_word.cell_col       = s_wr ? 8'(s_wr_col) : 8'd0;
        s_word.cell_char      = s_wr ? s_wr_ch : 8'd0;
        s_word.cursor_row_out = 7'(s_cr);
        s_word.cursor_col_out = 8'(s_cc);
        s_word.scrolled       = s_scroll;
        s_word.read_char      = 8'd0;
        s_word.last_result    = s_done;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (col_end && row_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    case (head.entry.kind)
                        KIND_TAB:  state_next = ST_TAB_DIV;
                        KIND_READ: state_next = ST_READ;
                        default:   state_next = ST_STEP;
                    endcase
                end
            end
            ST_TAB_DIV:
            begin
                state_next = ST_TAB_REM;
            end
            ST_TAB_REM:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (step_go)
                begin
                    if (it_reg.kind == KIND_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (s_scroll)
                    begin
                        state_next = ST_ROW_SWEEP;
                    end
                    else if (s_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                if (read_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROW_SWEEP:
            begin
                if (col_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, store writes and result word
    always_comb
    begin
        pop            = 1'b0;
        it_next        = it_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        tab_cnt_next   = tab_cnt_reg;
        tab_rem_next   = tab_rem_reg;
        tab_q_next     = tab_q_reg;
        swp_row_next   = swp_row_reg;
        swp_col_next   = swp_col_reg;
        mem_we         = 1'b0;
        mem_waddr      = {phys_row(s_wr_row, top_reg), s_wr_col};
        mem_wdata      = s_wr_ch;
        out_valid_next = rsp.ready ? 1'b0 : out_valid_reg;
        out_word_next  = out_word_reg;
        case (state_reg)
            ST_CLEAR, ST_ROW_SWEEP:
            begin
                // Blank one cell per cycle
                mem_we       = 1'b1;
                mem_waddr    = {swp_row_reg, swp_col_reg};
                mem_wdata    = CHAR_SPACE;
                swp_col_next = col_end ? '0 : swp_col_reg + CW'(1);
                if (col_end && state_reg == ST_CLEAR)
                begin
                    swp_row_next = row_end ? '0 : swp_row_reg + RW'(1);
                end
            end
            ST_IDLE:
            begin
                // Take the next word and pull the cursor into the shown area
                if (head.valid)
                begin
                    pop          = 1'b1;
                    it_next      = head.entry;
                    tab_cnt_next = '0;
                    if (cur_row_reg > rows_m1)
                    begin
                        cur_row_next = rows_m1;
                    end
                    if (cur_col_reg > cols_m1)
                    begin
                        cur_col_next = cols_m1;
                    end
                end
            end
            ST_TAB_DIV:
            begin
                tab_q_next = CW'((PW'(cur_col_reg) * PW'(RECIP)) >> DS);
            end
            ST_TAB_REM:
            begin
                tab_rem_next = (rem_diff >= RMW'(TAB_WIDTH))
                             ? TBW'(rem_diff - RMW'(TAB_WIDTH)) : TBW'(rem_diff);
            end
            ST_STEP:
            begin
                if (step_go)
                begin
                    mem_we       = s_wr;
                    cur_row_next = s_cr;
                    cur_col_next = s_cc;
                    top_next     = s_top;
                    tab_rem_next = tab_rem_reg + TBW'(1);
                    if (tab_cnt_reg != 2'd3)
                    begin
                        tab_cnt_next = tab_cnt_reg + 2'd1;
                    end
                    if (s_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = s_word;
                    end
                    if (it_reg.kind == KIND_CLEAR)
                    begin
                        swp_row_next = '0;
                        swp_col_next = '0;
                    end
                    else if (s_scroll)
                    begin
                        swp_row_next = phys_row(rows_m1, s_top);
                        swp_col_next = '0;
                    end
                end
            end
            ST_READ:
            begin
                if (read_go)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next                = '0;
                    out_word_next.cursor_row_out = 7'(cur_row_reg);
                    out_word_next.cursor_col_out = 8'(cur_col_reg);
                    out_word_next.read_char      = wr_in_range ? rd_data_reg : CHAR_SPACE;
                    out_word_next.last_result    = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            tab_cnt_reg   <= '0;
            swp_row_reg   <= '0;
            swp_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            tab_cnt_reg   <= tab_cnt_next;
            swp_row_reg   <= swp_row_next;
            swp_col_reg   <= swp_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        it_reg       <= it_next;
        tab_rem_reg  <= tab_rem_next;
        tab_q_reg    <= tab_q_next;
        out_word_reg <= out_word_next;
    end

    // Store: one write port, one registered read port sampled as a word
    // leaves the queue and held until the read result goes out
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Drive the result channel
    assign rsp.valid          = out_valid_reg;
    assign rsp.cell_written   = out_word_reg.cell_written;
    assign rsp.cell_row       = out_word_reg.cell_row;
    assign rsp.cell_col       = out_word_reg.cell_col;
    assign rsp.cell_char      = out_word_reg.cell_char;
    assign rsp.cursor_row_out = out_word_reg.cursor_row_out;
    assign rsp.cursor_col_out = out_word_reg.cursor_col_out;
    assign rsp.scrolled       = out_word_reg.scrolled;
    assign rsp.read_char      = out_word_reg.read_char;
    assign rsp.last_result    = out_word_reg.last_result;

endmodule

[rtl/text_console_cell_controller.sv]
`timescale 1ns / 1ps
// ============================================================================
// text_console_cell_controller
// Character-cell console with a cursor, line wrap, ring-offset scrolling,
// cell read/write, clear and cursor placement.
// ============================================================================
//
//  channel | role   | word
//  --------+--------+--------------------------------------------------
//  cmd     | sink   | opcode, char_in, row_in, col_in
//  rsp     | source | cell update, cursor, scrolled, read_char, last_result
//  cfg     | sink   | index 0 columns_in_use, index 1 rows_in_use
//
//  A command is taken from the queue and then executed in the back end;
//  a tab first works out the tab-stop remainder and then writes its
//  spaces one per step.
//  A scroll blanks the new bottom row at one cell per cycle. Clear and
//  reset sweep the whole store one cell per cycle; commands queue up
//  meanwhile and configuration writes are taken at any time.
//  The front keeps taking commands while the 2-entry queue has room, and
//  the back waits only when the result register is still full.
//
module text_console_cell_controller #(
    parameter int MAX_COLUMNS = tccc_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = tccc_pkg::DEF_MAX_ROWS,
    parameter int TAB_WIDTH   = tccc_pkg::DEF_TAB_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    tccc_cmd_if.sink   cmd,
    tccc_rsp_if.source rsp,
    tccc_cfg_if.sink   cfg
);
    import tccc_pkg::*;

    localparam int CNW = $clog2(MAX_COLUMNS + 1);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int COLS_INIT = (COLS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLS_RESET;
    localparam int ROWS_INIT = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

    logic [CNW-1:0] cols_reg;
    logic [CNW-1:0] cols_next;
    logic [RNW-1:0] rows_reg;
    logic [RNW-1:0] rows_next;
    logic [7:0]     rows_data;
    q_push_t        push;
    q_head_t        head;
    logic           q_full;
    logic           pop;

    assign cfg.ready = 1'b1;
    assign rows_data = cfg.data[7:0];

    // Hold the shown geometry, limited to 1..maximum on write
    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_COLUMNS:
                begin
                    if (cfg.data == '0)
                    begin
                        cols_next = CNW'(1);
                    end
                    else if (32'(cfg.data) > 32'(MAX_COLUMNS))
                    begin
                        cols_next = CNW'(MAX_COLUMNS);
                    end
                    else
                    begin
                        cols_next = CNW'(cfg.data);
                    end
                end
                REG_ROWS:
                begin
                    if (rows_data == '0)
                    begin
                        rows_next = RNW'(1);
                    end
                    else if (32'(rows_data) > 32'(MAX_ROWS))
                    begin
                        rows_next = RNW'(MAX_ROWS);
                    end
                    else
                    begin
                        rows_next = RNW'(rows_data);
                    end
                end
                default:
                begin
                    cols_next = cols_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CNW'(COLS_INIT);
            rows_reg <= RNW'(ROWS_INIT);
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    tccc_front u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .push   (push)
    );

    tccc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    tccc_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAB_WIDTH   (TAB_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .shown_cols (cols_reg),
        .shown_rows (rows_reg),
        .rsp        (rsp)
    );

endmodule
